[design/skf_pkg.sv]
package skf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int NOISE_W = DATA_WIDTH - 1;
  localparam int DEN_W   = DATA_WIDTH + 1;
  localparam int REM_W   = DATA_WIDTH + 2;
  localparam int GAIN_W  = FRAC_BITS + 1;
  localparam int DIFF_W  = DATA_WIDTH + 1;
  localparam int MOP_W   = FRAC_BITS + 2;
  localparam int PROD_W  = DIFF_W + MOP_W;
  localparam int CNT_W   = $clog2(GAIN_W);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(FRAC_BITS);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

  typedef struct packed {
    logic load;
    logic den;
    logic div_first;
    logic div_step;
    logic mul_est;
    logic mul_var;
    logic upd_var;
    logic out_load;
  } skf_cmd_t;

  typedef struct packed {
    logic out_free;
  } skf_stat_t;

endpackage

[design/skf_in_if.sv]
interface skf_in_if;
  import skf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

[design/skf_out_if.sv]
interface skf_out_if;
  import skf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] estimate;

  modport source (output valid, output estimate, input ready);
  modport sink (input valid, input estimate, output ready);
endinterface

[design/skf_ctrl.sv]
module skf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  skf_pkg::skf_stat_t stat,
  output skf_pkg::skf_cmd_t  cmd
);
  import skf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEN  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MULE = 3'd3;
  localparam logic [2:0] ST_MULV = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd.den   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_MULE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_MULE: begin
        cmd.mul_est = 1'b1;
        state_nxt   = ST_MULV;
      end
      ST_MULV: begin
        cmd.mul_var = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd_var = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_accept_to_den: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DEN))
    else $error("accepted item did not start the denominator step");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("division step count out of range");

endmodule

[design/skf_dp.sv]
module skf_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  skf_pkg::skf_cmd_t                     cmd,
  output skf_pkg::skf_stat_t                    stat,
  input  logic                                  cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [skf_pkg::NOISE_W-1:0]           cfg_wdata,
  input  logic signed [skf_pkg::DATA_WIDTH-1:0] measurement,
  output logic signed [skf_pkg::DATA_WIDTH-1:0] estimate,
  output logic                                  out_valid,
  input  logic                                  out_ready
);
  import skf_pkg::*;

  // state and configuration
  logic signed [DATA_WIDTH-1:0] est_r, est_nxt;
  logic [DATA_WIDTH-1:0]        var_r, var_nxt;
  logic [NOISE_W-1:0]           q_r, q_nxt;
  logic [NOISE_W-1:0]           rn_r, rn_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // working registers
  logic signed [DATA_WIDTH-1:0] z_r, z_nxt;
  logic [DATA_WIDTH-1:0]        pmid_r, pmid_nxt;
  logic [DEN_W-1:0]             den_r, den_nxt;
  logic                         den_zero_r, den_zero_nxt;
  logic signed [DIFF_W-1:0]     diff_r, diff_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [GAIN_W-1:0]            quo_r, quo_nxt;
  logic signed [PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [DATA_WIDTH-1:0] out_data_r, out_data_nxt;

  logic [DEN_W-1:0]         pred_sum;
  logic [DATA_WIDTH-1:0]    pred_sat;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         den_ext;
  logic                     ge;
  logic [GAIN_W-1:0]        gain;
  logic signed [DIFF_W-1:0] mop_a;
  logic signed [MOP_W-1:0]  mop_b;

  always_comb begin
    // saturating variance prediction
    pred_sum = {1'b0, var_r} + DEN_W'(q_r);
    pred_sat = pred_sum[DATA_WIDTH] ? '1 : pred_sum[DATA_WIDTH-1:0];

    // one restoring division step
    den_ext = REM_W'(den_r);
    rem_sh  = cmd.div_first ? rem_r : (rem_r << 1);
    ge      = (rem_sh >= den_ext);

    gain = den_zero_r ? '0 : quo_r;

    // shared multiplier operands
    if (cmd.mul_est) begin
      mop_a = diff_r;
      mop_b = $signed({1'b0, gain});
    end else begin
      mop_a = $signed({1'b0, pmid_r});
      mop_b = $signed({1'b0, GAIN_ONE - gain});
    end

    est_nxt       = est_r;
    var_nxt       = var_r;
    q_nxt         = q_r;
    rn_nxt        = rn_r;
    z_nxt         = z_r;
    pmid_nxt      = pmid_r;
    den_nxt       = den_r;
    den_zero_nxt  = den_zero_r;
    diff_nxt      = diff_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE:     q_nxt  = cfg_wdata;
        REG_MEASUREMENT_NOISE: rn_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end

    if (cmd.load) begin
      z_nxt    = measurement;
      pmid_nxt = pred_sat;
    end

    if (cmd.den) begin
      den_nxt      = {1'b0, pmid_r} + DEN_W'(rn_r);
      den_zero_nxt = (pmid_r == '0) && (rn_r == '0);
      diff_nxt     = {z_r[DATA_WIDTH-1], z_r} - {est_r[DATA_WIDTH-1], est_r};
      rem_nxt      = REM_W'(pmid_r);
      quo_nxt      = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = ge ? (rem_sh - den_ext) : rem_sh;
      quo_nxt = cmd.div_first ? GAIN_W'(ge) : {quo_r[GAIN_W-2:0], ge};
    end

    if (cmd.mul_est || cmd.mul_var) begin
      prod_nxt = mop_a * mop_b;
    end

    if (cmd.mul_var) begin
      est_nxt = est_r + $signed(prod_r[FRAC_BITS +: DATA_WIDTH]);
    end

    if (cmd.upd_var) begin
      var_nxt = prod_r[FRAC_BITS +: DATA_WIDTH];
    end

    if (cmd.out_load) begin
      out_data_nxt  = est_r;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r       <= '0;
      var_r       <= '0;
      q_r         <= '0;
      rn_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      q_r         <= q_nxt;
      rn_r        <= rn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r        <= z_nxt;
    pmid_r     <= pmid_nxt;
    den_r      <= den_nxt;
    den_zero_r <= den_zero_nxt;
    diff_r     <= diff_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign estimate      = out_data_r;
  assign out_valid     = out_valid_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (den_zero_r || (rem_r < REM_W'(den_r))))
    else $error("division remainder not below denominator");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_est |-> (gain <= GAIN_ONE))
    else $error("gain above one");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrote an item not yet taken");

endmodule

[design/scalar_kalman_filter.sv]
// One-dimensional Kalman filter on signed Q16.16 samples. Each accepted item
// runs through a saturating variance prediction, a restoring division for the
// unsigned Q1.16 gain (one quotient bit per cycle), and two passes through a
// single shared 33x18 multiplier for the estimate and variance updates. The
// next item is accepted only after the estimate of the last one is loaded
// into the output register, which waits while the result side stalls. Both
// noise registers and the filter state clear to zero on reset; write the
// noise registers only while no item is in flight.
module scalar_kalman_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  skf_in_if.sink                        in_ch,
  skf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skf_pkg::NOISE_W-1:0]   cfg_wdata
);
  import skf_pkg::*;

  skf_cmd_t  cmd;
  skf_stat_t stat;

  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  skf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .measurement (in_ch.measurement),
    .estimate    (out_ch.estimate),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready)
  );

endmodule
